// ----- rtl/mbc_pkg.sv -----
// Shared types, codes and the direction-order table of the maze carver.
package mbc_pkg;

   localparam logic [2:0] ST_STARTED     = 3'd0;
   localparam logic [2:0] ST_CARVED      = 3'd1;
   localparam logic [2:0] ST_BACKTRACKED = 3'd2;
   localparam logic [2:0] ST_FINISHED    = 3'd3;
   localparam logic [2:0] ST_IGNORED     = 3'd4;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   localparam logic [6:0] SIZE_RESET = 7'd64;
   localparam int unsigned NUM_ORDERS = 24;

   typedef struct packed {
      logic accept;
      logic clear_start;
      logic clear_step;
      logic start_write;
      logic stk_rd;
      logic load_frame;
      logic scan;
      logic grid_rd;
      logic carve_a;
      logic carve_b;
      logic pop;
      logic res_ignored;
      logic res_finished;
      logic res_back;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic active;
      logic full;
      logic clear_done;
      logic slot_done;
      logic dir_ok;
      logic cell_free;
      logic sp_zero;
      logic out_free;
   } stat_type;

   function automatic logic [7:0] dir_order(input logic [4:0] idx);
      logic [7:0] r;
      unique case (idx)
         5'd0:  r = 8'h1B;  5'd1:  r = 8'h1E;  5'd2:  r = 8'h27;  5'd3:  r = 8'h2D;
         5'd4:  r = 8'h36;  5'd5:  r = 8'h39;  5'd6:  r = 8'h4B;  5'd7:  r = 8'h4E;
         5'd8:  r = 8'h63;  5'd9:  r = 8'h6C;  5'd10: r = 8'h72;  5'd11: r = 8'h78;
         5'd12: r = 8'h87;  5'd13: r = 8'h8D;  5'd14: r = 8'h93;  5'd15: r = 8'h9C;
         5'd16: r = 8'hB1;  5'd17: r = 8'hB4;  5'd18: r = 8'hC6;  5'd19: r = 8'hC9;
         5'd20: r = 8'hD2;  5'd21: r = 8'hD8;  5'd22: r = 8'hE1;  5'd23: r = 8'hE4;
         default: r = 8'h1B;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/mbc_ctrl.sv -----
// Sequencer of the maze carver: decodes items and steps the datapath.
module mbc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mbc_pkg::stat_type stat,
   output mbc_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CLEAR, S_START_WR, S_FRM_WAIT, S_SCAN,
      S_CHECK, S_CARVE_B, S_POP_CHK, S_BACK_WAIT, S_RESULT
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.is_start) begin
               cmd.clear_start = 1'b1;
               state_in        = S_CLEAR;
            end else if (!stat.active) begin
               cmd.res_ignored = 1'b1;
               state_in        = S_RESULT;
            end else if (stat.full) begin
               cmd.pop  = 1'b1;
               state_in = S_POP_CHK;
            end else begin
               cmd.stk_rd = 1'b1;
               state_in   = S_FRM_WAIT;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = S_START_WR;
         end
         S_START_WR: begin
            cmd.start_write = 1'b1;
            state_in        = S_RESULT;
         end
         S_FRM_WAIT: begin
            cmd.load_frame = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (stat.slot_done) begin
               cmd.pop  = 1'b1;
               state_in = S_POP_CHK;
            end else begin
               cmd.scan = 1'b1;
               if (stat.dir_ok) begin
                  cmd.grid_rd = 1'b1;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (stat.cell_free) begin
               cmd.carve_a = 1'b1;
               state_in    = S_CARVE_B;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_CARVE_B: begin
            cmd.carve_b = 1'b1;
            state_in    = S_RESULT;
         end
         S_POP_CHK: begin
            if (stat.sp_zero) begin
               cmd.res_finished = 1'b1;
               state_in         = S_RESULT;
            end else begin
               cmd.stk_rd = 1'b1;
               state_in   = S_BACK_WAIT;
            end
         end
         S_BACK_WAIT: begin
            cmd.res_back = 1'b1;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/mbc_dp.sv -----
// Datapath of the maze carver: grid and stack memories, frame and result registers.
module mbc_dp #(
   parameter int unsigned MAX_WIDTH   = 64,
   parameter int unsigned MAX_HEIGHT  = 64,
   parameter int unsigned STACK_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [6:0]        csr_wdata,
   input  logic              req_type,
   input  logic [5:0]        req_start_x,
   input  logic [5:0]        req_start_y,
   input  logic [4:0]        req_perm_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [5:0]        rsp_between_x,
   output logic [5:0]        rsp_between_y,
   output logic [5:0]        rsp_cell_x,
   output logic [5:0]        rsp_cell_y,
   input  mbc_pkg::cmd_type  cmd,
   output mbc_pkg::stat_type stat
);

   localparam int unsigned XW  = $clog2(MAX_WIDTH);
   localparam int unsigned YW  = $clog2(MAX_HEIGHT);
   localparam int unsigned GD  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW  = $clog2(GD);
   localparam int unsigned SAW = $clog2(STACK_DEPTH);
   localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned FW  = XW + YW + 8;

   // config
   logic [6:0] width_ff, height_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbc_pkg::SIZE_RESET;
         height_ff <= mbc_pkg::SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mbc_pkg::REG_GRID_WIDTH:  width_ff  <= csr_wdata;
            mbc_pkg::REG_GRID_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective sizes: zero counts as one, saturate at the maximum
   logic [9:0] w_eff, h_eff;
   always_comb begin
      priority if (width_ff == 7'd0)                 w_eff = 10'd1;
      else if (10'(width_ff) > 10'(MAX_WIDTH))       w_eff = 10'(MAX_WIDTH);
      else                                           w_eff = 10'(width_ff);
      priority if (height_ff == 7'd0)                h_eff = 10'd1;
      else if (10'(height_ff) > 10'(MAX_HEIGHT))     h_eff = 10'(MAX_HEIGHT);
      else                                           h_eff = 10'(height_ff);
   end

   // latched request
   logic          rtype_ff;
   logic [XW-1:0] sx_ff;
   logic [YW-1:0] sy_ff;
   logic [4:0]    perm_ff;
   logic [9:0]    sx_cl, sy_cl;
   always_comb begin
      sx_cl = (10'(req_start_x) > w_eff - 10'd1) ? w_eff - 10'd1 : 10'(req_start_x);
      sy_cl = (10'(req_start_y) > h_eff - 10'd1) ? h_eff - 10'd1 : 10'(req_start_y);
   end
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rtype_ff <= req_type;
         sx_ff    <= XW'(sx_cl);
         sy_ff    <= YW'(sy_cl);
         perm_ff  <= (req_perm_index >= 5'(mbc_pkg::NUM_ORDERS)) ?
                     req_perm_index - 5'(mbc_pkg::NUM_ORDERS) : req_perm_index;
      end
   end

   // control state
   logic [SPW-1:0] sp_ff;
   logic           gen_ff;
   logic [AW-1:0]  clr_ff;

   // frame being worked on
   logic [XW-1:0] frm_x_ff;
   logic [YW-1:0] frm_y_ff;
   logic [4:0]    frm_ord_ff;
   logic [2:0]    frm_slot_ff;
   logic [XW-1:0] tgt_x_ff, btw_x_ff;
   logic [YW-1:0] tgt_y_ff, btw_y_ff;

   // direction of the current slot
   logic [7:0]    ord_byte;
   logic [1:0]    dir;
   logic          dir_ok;
   logic [9:0]    x10, y10;
   logic [XW-1:0] tx, bx;
   logic [YW-1:0] ty, by;
   always_comb begin
      ord_byte = mbc_pkg::dir_order(frm_ord_ff);
      dir      = 2'(ord_byte >> {frm_slot_ff[1:0], 1'b0});
      x10      = 10'(frm_x_ff);
      y10      = 10'(frm_y_ff);
      tx = frm_x_ff;  bx = frm_x_ff;
      ty = frm_y_ff;  by = frm_y_ff;
      dir_ok = 1'b0;
      unique case (dir)
         mbc_pkg::DIR_LEFT: begin
            dir_ok = (x10 > 10'd1);
            tx = XW'(x10 - 10'd2);  bx = XW'(x10 - 10'd1);
         end
         mbc_pkg::DIR_UP: begin
            dir_ok = (y10 > 10'd1);
            ty = YW'(y10 - 10'd2);  by = YW'(y10 - 10'd1);
         end
         mbc_pkg::DIR_RIGHT: begin
            dir_ok = (x10 + 10'd2 < w_eff);
            tx = XW'(x10 + 10'd2);  bx = XW'(x10 + 10'd1);
         end
         mbc_pkg::DIR_DOWN: begin
            dir_ok = (y10 + 10'd2 < h_eff);
            ty = YW'(y10 + 10'd2);  by = YW'(y10 + 10'd1);
         end
         default: ;
      endcase
   end

   function automatic logic [AW-1:0] gaddr(input logic [XW-1:0] x, input logic [YW-1:0] y);
      return AW'(32'(y) * MAX_WIDTH + 32'(x));
   endfunction

   // grid memory, one bit per cell
   logic          grid_mem [GD];
   logic          grid_rd_ff;
   logic          g_we, g_wd;
   logic [AW-1:0] g_wa;
   always_comb begin
      g_we = 1'b1;
      g_wd = 1'b1;
      g_wa = gaddr(tgt_x_ff, tgt_y_ff);
      priority if (cmd.clear_step) begin
         g_wa = clr_ff;  g_wd = 1'b0;
      end else if (cmd.start_write) begin
         g_wa = gaddr(sx_ff, sy_ff);
      end else if (cmd.carve_a) begin
         g_wa = gaddr(btw_x_ff, btw_y_ff);
      end else if (cmd.carve_b) begin
         g_wa = gaddr(tgt_x_ff, tgt_y_ff);
      end else begin
         g_we = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (g_we) grid_mem[g_wa] <= g_wd;
      if (cmd.grid_rd) grid_rd_ff <= grid_mem[gaddr(tx, ty)];
   end

   // frame stack memory: {x, y, order, slot}
   logic [FW-1:0]  stk_mem [STACK_DEPTH];
   logic [FW-1:0]  stk_rd_ff;
   logic           s_we;
   logic [SAW-1:0] s_wa;
   logic [FW-1:0]  s_wd;
   logic [SPW-1:0] sp_m1;
   assign sp_m1 = sp_ff - SPW'(1);
   always_comb begin
      s_we = 1'b1;
      s_wa = SAW'(0);
      s_wd = {frm_x_ff, frm_y_ff, frm_ord_ff, frm_slot_ff};
      priority if (cmd.start_write) begin
         s_wd = {sx_ff, sy_ff, perm_ff, 3'd0};
      end else if (cmd.carve_a) begin
         s_wa = sp_m1[SAW-1:0];
      end else if (cmd.carve_b) begin
         s_wa = sp_ff[SAW-1:0];
         s_wd = {tgt_x_ff, tgt_y_ff, perm_ff, 3'd0};
      end else begin
         s_we = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (s_we) stk_mem[s_wa] <= s_wd;
      if (cmd.stk_rd) stk_rd_ff <= stk_mem[sp_m1[SAW-1:0]];
   end

   logic [XW-1:0] rd_x;
   logic [YW-1:0] rd_y;
   assign rd_x = stk_rd_ff[FW-1 -: XW];
   assign rd_y = stk_rd_ff[FW-XW-1 -: YW];

   always_ff @(posedge clock) begin
      if (cmd.load_frame) begin
         frm_x_ff    <= rd_x;
         frm_y_ff    <= rd_y;
         frm_ord_ff  <= stk_rd_ff[7:3];
         frm_slot_ff <= stk_rd_ff[2:0];
      end else if (cmd.scan) begin
         frm_slot_ff <= frm_slot_ff + 3'd1;
         tgt_x_ff    <= tx;
         tgt_y_ff    <= ty;
         btw_x_ff    <= bx;
         btw_y_ff    <= by;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         gen_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         if (cmd.clear_start) clr_ff <= '0;
         else if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.start_write) begin
            sp_ff  <= SPW'(1);
            gen_ff <= 1'b1;
         end else if (cmd.carve_b) begin
            sp_ff <= sp_ff + SPW'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_m1;
         end
         if (cmd.res_ignored || cmd.res_finished) gen_ff <= 1'b0;
      end
   end

   // result staging and output register
   logic [2:0] res_st_ff;
   logic [5:0] res_bx_ff, res_by_ff, res_cx_ff, res_cy_ff;
   always_ff @(posedge clock) begin
      priority if (cmd.start_write) begin
         res_st_ff <= mbc_pkg::ST_STARTED;
         res_bx_ff <= '0;  res_by_ff <= '0;
         res_cx_ff <= 6'(sx_ff);  res_cy_ff <= 6'(sy_ff);
      end else if (cmd.carve_b) begin
         res_st_ff <= mbc_pkg::ST_CARVED;
         res_bx_ff <= 6'(btw_x_ff);  res_by_ff <= 6'(btw_y_ff);
         res_cx_ff <= 6'(tgt_x_ff);  res_cy_ff <= 6'(tgt_y_ff);
      end else if (cmd.res_back) begin
         res_st_ff <= mbc_pkg::ST_BACKTRACKED;
         res_bx_ff <= '0;  res_by_ff <= '0;
         res_cx_ff <= 6'(rd_x);  res_cy_ff <= 6'(rd_y);
      end else if (cmd.res_finished || cmd.res_ignored) begin
         res_st_ff <= cmd.res_finished ? mbc_pkg::ST_FINISHED : mbc_pkg::ST_IGNORED;
         res_bx_ff <= '0;  res_by_ff <= '0;
         res_cx_ff <= '0;  res_cy_ff <= '0;
      end else begin
         res_st_ff <= res_st_ff;
      end
   end

   logic rsp_valid_ff, rsp_valid_in;
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end
   logic [2:0] rsp_st_ff;
   logic [5:0] rsp_bx_ff, rsp_by_ff, rsp_cx_ff, rsp_cy_ff;
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_st_ff <= res_st_ff;
         rsp_bx_ff <= res_bx_ff;  rsp_by_ff <= res_by_ff;
         rsp_cx_ff <= res_cx_ff;  rsp_cy_ff <= res_cy_ff;
      end
   end
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_st_ff;
   assign rsp_between_x = rsp_bx_ff;
   assign rsp_between_y = rsp_by_ff;
   assign rsp_cell_x    = rsp_cx_ff;
   assign rsp_cell_y    = rsp_cy_ff;

   always_comb begin
      stat.is_start   = (rtype_ff == mbc_pkg::REQ_START);
      stat.active     = gen_ff && (sp_ff != '0);
      stat.full       = (sp_ff == SPW'(STACK_DEPTH));
      stat.clear_done = (clr_ff == AW'(GD - 1));
      stat.slot_done  = frm_slot_ff[2];
      stat.dir_ok     = dir_ok;
      stat.cell_free  = !grid_rd_ff;
      stat.sp_zero    = (sp_ff == '0);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH)) else $error("stack pointer past depth");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.carve_b |-> sp_ff < SPW'(STACK_DEPTH)) else $error("push on full stack");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall)) else $error("result overwritten");
   a_gen_start: assert property (@(posedge clock) disable iff (reset)
      $rose(gen_ff) |-> sp_ff == SPW'(1)) else $error("generation began without start frame");

endmodule

// ----- rtl/maze_backtracker_carver.sv -----
// Top level of the recursive-backtracker maze carver.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_type, req_start_x/y, req_perm_index
//  rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_between_x/y, rsp_cell_x/y
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// One item at a time. A carving step reads the top frame from the stack, then
// scans its slots in the frame's direction order, skipping slots out of bounds and
// reading the grid for the others, and carves towards the first target not yet path.
// A popping step, taken when no slot is left or the stack is full, pops the frame and
// reports the new top cell, or finishes when it empties the stack; a step with no
// generation active is ignored. A start item sweeps the whole grid one cell per cycle.
// Reset is synchronous; grid is not cleared at reset (steps stay ignored until
// a start). A stalled result is held in the output register; the next item is
// already accepted and waits for it only at the moment its own result is ready.
module maze_backtracker_carver #(
   parameter int unsigned MAX_WIDTH   = 64,
   parameter int unsigned MAX_HEIGHT  = 64,
   parameter int unsigned STACK_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [5:0] req_start_x,
   input  logic [5:0] req_start_y,
   input  logic [4:0] req_perm_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_between_x,
   output logic [5:0] rsp_between_y,
   output logic [5:0] rsp_cell_x,
   output logic [5:0] rsp_cell_y,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   mbc_pkg::cmd_type  cmd;
   mbc_pkg::stat_type stat;

   // sequencer: decodes each item and walks the datapath through it
   mbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memories, frame registers and the output register
   mbc_dp #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_perm_index (req_perm_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_between_x  (rsp_between_x),
      .rsp_between_y  (rsp_between_y),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
